// File: rtl/sbpp_pkg.sv
// ----------------------------------------------------------------------------
// sbpp_pkg
// Shared constants, result codes and controller/datapath interface structs
// for the servo bus packet parser.
// ----------------------------------------------------------------------------
package sbpp_pkg;

  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 6;

  // Header byte, sent twice to open a packet
  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
  // Length byte counts instruction and checksum on top of the parameters
  localparam logic [BYTE_W-1:0] LEN_BIAS = 8'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_CSUM_ERR = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic              clr;         // start of packet: clear frame registers
    logic              ld_id;       // capture id byte
    logic              ld_len;      // capture length byte
    logic              ld_instr;    // capture instruction byte
    logic              wr_param;    // store parameter byte, advance position
    logic              res_single;  // load a single result with res_status
    logic [STAT_W-1:0] res_status;
    logic              rd_start;    // rewind the emit index
    logic              rd_param;    // read buffer at emit index, load result
    logic              emit_adv;    // advance the emit index
  } sbpp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hdr_match;   // current byte is a header byte
    logic body_more;   // parameter bytes still expected
    logic too_long;    // declared count exceeds the buffer
    logic sum_ok;      // current byte matches the inverted running sum
    logic count_zero;  // packet has no parameters
    logic emit_last;   // emit index points at the final parameter
    logic out_last;    // held result is the final one of the packet
  } sbpp_stat_t;

endpackage

// File: rtl/servo_bus_packet_parser.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_parser
// Parses header-framed servo bus instruction packets and reports each packet
// as a burst of parameter results, or one status result.
// ----------------------------------------------------------------------------
// Input: one byte per cycle while parsing; in_stall holds the input while a
// result waits. A status-only result is valid in the cycle after the
// checksum beat; a parameter burst begins with a buffer read state. Each
// parameter is read through the RAM's registered read port, the next once
// the last is taken; the burst ends with the input back in header hunt.
// Reset: synchronous, returns the parser to header hunt; buffer not cleared.
module servo_bus_packet_parser #(
  parameter int MAX_PARAMS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sbpp_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sbpp_pkg::STAT_W-1:0] out_packet_status,
  output logic [sbpp_pkg::BYTE_W-1:0] out_sender_id,
  output logic [sbpp_pkg::BYTE_W-1:0] out_instruction_code,
  output logic [sbpp_pkg::BYTE_W-1:0] out_param_total,
  output logic [sbpp_pkg::IDX_W-1:0]  out_param_index,
  output logic [sbpp_pkg::BYTE_W-1:0] out_param_value,
  output logic                        out_param_present,
  output logic                        out_last_of_packet
);

  import sbpp_pkg::*;

  sbpp_cmd_t  cmd;
  sbpp_stat_t stat;

  // Sequencer
  sbpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Frame fields, buffer and result register
  sbpp_dp #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk              (clk),
    .rx_byte          (in_rx_byte),
    .cmd              (cmd),
    .stat             (stat),
    .packet_status    (out_packet_status),
    .sender_id        (out_sender_id),
    .instruction_code (out_instruction_code),
    .param_total      (out_param_total),
    .param_index      (out_param_index),
    .param_value      (out_param_value),
    .param_present    (out_param_present),
    .last_of_packet   (out_last_of_packet)
  );

endmodule

// File: rtl/sbpp_ram.sv
// ----------------------------------------------------------------------------
// sbpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/sbpp_ctrl.sv
// ----------------------------------------------------------------------------
// sbpp_ctrl
// Packet parser controller: header hunt, field sequencing and result burst.
// ----------------------------------------------------------------------------
module sbpp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  sbpp_pkg::sbpp_stat_t stat,
  output sbpp_pkg::sbpp_cmd_t  cmd
);

  import sbpp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_HDR   = 8'b0000_0010,
    S_ID    = 8'b0000_0100,
    S_LEN   = 8'b0000_1000,
    S_INSTR = 8'b0001_0000,
    S_BODY  = 8'b0010_0000,
    S_READ  = 8'b0100_0000,
    S_SEND  = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy;
  logic   acc;

  // Hold the input while the result burst runs
  assign busy      = (state_r == S_READ) || (state_r == S_SEND);
  assign in_stall  = busy;
  assign acc       = in_valid && !busy;
  assign out_valid = (state_r == S_SEND);

  // Next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (acc && stat.hdr_match) begin
          cmd.clr   = 1'b1;
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        if (acc) begin
          state_nxt = stat.hdr_match ? S_ID : S_IDLE;
        end
      end
      S_ID: begin
        if (acc) begin
          cmd.ld_id = 1'b1;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (acc) begin
          cmd.ld_len = 1'b1;
          state_nxt  = S_INSTR;
        end
      end
      S_INSTR: begin
        if (acc) begin
          cmd.ld_instr = 1'b1;
          state_nxt    = S_BODY;
        end
      end
      S_BODY: begin
        if (acc) begin
          priority if (stat.body_more) begin
            cmd.wr_param = 1'b1;
          end else if (stat.too_long) begin
            cmd.res_single = 1'b1;
            cmd.res_status = ST_TOO_LONG;
            state_nxt      = S_SEND;
          end else if (!stat.sum_ok) begin
            cmd.res_single = 1'b1;
            cmd.res_status = ST_CSUM_ERR;
            state_nxt      = S_SEND;
          end else if (stat.count_zero) begin
            cmd.res_single = 1'b1;
            cmd.res_status = ST_OK;
            state_nxt      = S_SEND;
          end else begin
            cmd.rd_start = 1'b1;
            state_nxt    = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_param = 1'b1;
        state_nxt    = S_SEND;
      end
      S_SEND: begin
        if (!out_stall) begin
          if (stat.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.emit_adv = 1'b1;
            state_nxt    = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/sbpp_dp.sv
// ----------------------------------------------------------------------------
// sbpp_dp
// Packet parser datapath: frame fields, running sum, parameter buffer and
// the result register.
// ----------------------------------------------------------------------------
module sbpp_dp #(
  parameter int MAX_PARAMS = 64
) (
  input  logic                                clk,
  input  logic [sbpp_pkg::BYTE_W-1:0]          rx_byte,
  input  sbpp_pkg::sbpp_cmd_t                  cmd,
  output sbpp_pkg::sbpp_stat_t                 stat,
  output logic [sbpp_pkg::STAT_W-1:0]          packet_status,
  output logic [sbpp_pkg::BYTE_W-1:0]          sender_id,
  output logic [sbpp_pkg::BYTE_W-1:0]          instruction_code,
  output logic [sbpp_pkg::BYTE_W-1:0]          param_total,
  output logic [sbpp_pkg::IDX_W-1:0]           param_index,
  output logic [sbpp_pkg::BYTE_W-1:0]          param_value,
  output logic                                 param_present,
  output logic                                 last_of_packet
);

  import sbpp_pkg::*;

  localparam int                AW      = $clog2(MAX_PARAMS);
  localparam logic [BYTE_W-1:0] POS_MAX = BYTE_W'(MAX_PARAMS);

  logic [BYTE_W-1:0] id_r, id_nxt;
  logic [BYTE_W-1:0] count_r, count_nxt;
  logic [BYTE_W-1:0] instr_r, instr_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic [AW-1:0]     emit_r, emit_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              present_r, present_nxt;
  logic              last_r, last_nxt;
  logic              ram_wr_en;
  logic [BYTE_W-1:0] ram_q;

  // Status toward the controller
  assign stat.hdr_match  = (rx_byte == HDR_BYTE);
  assign stat.body_more  = (pos_r < count_r);
  assign stat.too_long   = (count_r > POS_MAX);
  assign stat.sum_ok     = (~sum_r == rx_byte);
  assign stat.count_zero = (count_r == '0);
  assign stat.emit_last  = ((BYTE_W'(emit_r) + 8'd1) == count_r);
  assign stat.out_last   = last_r;

  // Frame fields, running sum, emit index and result register
  always_comb begin
    id_nxt      = id_r;
    count_nxt   = count_r;
    instr_nxt   = instr_r;
    sum_nxt     = sum_r;
    pos_nxt     = pos_r;
    emit_nxt    = emit_r;
    status_nxt  = status_r;
    idx_nxt     = idx_r;
    present_nxt = present_r;
    last_nxt    = last_r;
    if (cmd.clr) begin
      id_nxt    = '0;
      count_nxt = '0;
      instr_nxt = '0;
      sum_nxt   = '0;
      pos_nxt   = '0;
    end
    if (cmd.ld_id) begin
      id_nxt  = rx_byte;
      sum_nxt = sum_r + rx_byte;
    end
    if (cmd.ld_len) begin
      sum_nxt   = sum_r + rx_byte;
      count_nxt = (rx_byte >= LEN_BIAS) ? (rx_byte - LEN_BIAS) : rx_byte;
    end
    if (cmd.ld_instr) begin
      instr_nxt = rx_byte;
      sum_nxt   = sum_r + rx_byte;
      pos_nxt   = '0;
    end
    if (cmd.wr_param) begin
      pos_nxt = pos_r + 8'd1;
      sum_nxt = sum_r + rx_byte;
    end
    // Load a lone result: status only, no parameter byte
    if (cmd.res_single) begin
      status_nxt  = cmd.res_status;
      idx_nxt     = '0;
      present_nxt = 1'b0;
      last_nxt    = 1'b1;
    end
    if (cmd.rd_start) begin
      emit_nxt = '0;
    end
    // Load one parameter result; its byte lands in the RAM read register
    if (cmd.rd_param) begin
      status_nxt  = ST_OK;
      idx_nxt     = IDX_W'(emit_r);
      present_nxt = 1'b1;
      last_nxt    = stat.emit_last;
    end
    if (cmd.emit_adv) begin
      emit_nxt = emit_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    count_r   <= count_nxt;
    instr_r   <= instr_nxt;
    sum_r     <= sum_nxt;
    pos_r     <= pos_nxt;
    emit_r    <= emit_nxt;
    status_r  <= status_nxt;
    idx_r     <= idx_nxt;
    present_r <= present_nxt;
    last_r    <= last_nxt;
  end

  // Parameter buffer; bytes past its end only feed the sum
  assign ram_wr_en = cmd.wr_param && (pos_r < POS_MAX);

  sbpp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PARAMS)
  ) u_param_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (pos_r[AW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (cmd.rd_param),
    .rd_addr (emit_r),
    .rd_data (ram_q)
  );

  // Result payload
  assign packet_status    = status_r;
  assign sender_id        = id_r;
  assign instruction_code = instr_r;
  assign param_total      = count_r;
  assign param_index      = idx_r;
  assign param_value      = present_r ? ram_q : '0;
  assign param_present    = present_r;
  assign last_of_packet   = last_r;

endmodule

// File: bench/packet_checker.sv
// ----------------------------------------------------------------------------
// packet_checker
// Watches the byte input and the result output of the servo bus packet
// parser. A software copy of the parser turns every accepted byte into the
// results it must cause. Each result beat is compared field by field with
// the oldest of those.
// ----------------------------------------------------------------------------
module packet_checker
  import sbpp_pkg::*;
#(
  parameter int MAX_PARAMS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [STAT_W-1:0] out_packet_status,
  input  logic [BYTE_W-1:0] out_sender_id,
  input  logic [BYTE_W-1:0] out_instruction_code,
  input  logic [BYTE_W-1:0] out_param_total,
  input  logic [IDX_W-1:0]  out_param_index,
  input  logic [BYTE_W-1:0] out_param_value,
  input  logic              out_param_present,
  input  logic              out_last_of_packet,
  output int                fail_count,
  output int                pending_count,
  output int                result_count
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    HUNT,
    SECOND_HDR,
    GET_ID,
    GET_LEN,
    GET_INSTR,
    GET_BODY
  } parse_phase_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] sender_id;
    logic [BYTE_W-1:0] instr;
    logic [BYTE_W-1:0] total;
    logic [IDX_W-1:0]  index;
    logic [BYTE_W-1:0] value;
    logic              present;
    logic              last;
  } packet_report_t;

  // Mirror of the parser state
  parse_phase_t      phase;
  logic [BYTE_W-1:0] frame_id;
  logic [BYTE_W-1:0] frame_count;
  logic [BYTE_W-1:0] frame_instr;
  logic [BYTE_W-1:0] frame_sum;
  logic [BYTE_W-1:0] body_pos;
  logic [BYTE_W-1:0] param_buf [MAX_PARAMS];

  packet_report_t    packet_reports [$];

  // Queue one result of the current frame
  task automatic queue_report(input logic [STAT_W-1:0] status, input int idx,
                              input logic [BYTE_W-1:0] value, input logic present,
                              input logic last);
    packet_report_t r;
    r.status    = status;
    r.sender_id = frame_id;
    r.instr     = frame_instr;
    r.total     = frame_count;
    r.index     = IDX_W'(idx);
    r.value     = value;
    r.present   = present;
    r.last      = last;
    packet_reports.push_back(r);
  endtask

  // Advance the parser copy by one received byte
  task automatic parse_byte(input logic [BYTE_W-1:0] b);
    int i;
    case (phase)
      HUNT: begin
        if (b == HDR_BYTE) begin
          phase       = SECOND_HDR;
          frame_sum   = '0;
          frame_id    = '0;
          frame_count = '0;
          frame_instr = '0;
          body_pos    = '0;
        end
      end
      SECOND_HDR: phase = (b == HDR_BYTE) ? GET_ID : HUNT;
      GET_ID: begin
        frame_id  = b;
        frame_sum = frame_sum + b;
        phase     = GET_LEN;
      end
      GET_LEN: begin
        // Length covers instruction and checksum; 0 and 1 are taken as is
        frame_sum   = frame_sum + b;
        frame_count = (b >= LEN_BIAS) ? b - LEN_BIAS : b;
        phase       = GET_INSTR;
      end
      GET_INSTR: begin
        frame_instr = b;
        frame_sum   = frame_sum + b;
        body_pos    = '0;
        phase       = GET_BODY;
      end
      GET_BODY: begin
        if (body_pos < frame_count) begin
          // Bytes past the buffer still count toward the sum
          if (body_pos < MAX_PARAMS) param_buf[body_pos] = b;
          body_pos  = body_pos + 1'b1;
          frame_sum = frame_sum + b;
        end else begin
          phase = HUNT;
          if (frame_count > MAX_PARAMS) begin
            queue_report(ST_TOO_LONG, 0, '0, 1'b0, 1'b1);
          end else if (~frame_sum != b) begin
            queue_report(ST_CSUM_ERR, 0, '0, 1'b0, 1'b1);
          end else if (frame_count == 0) begin
            queue_report(ST_OK, 0, '0, 1'b0, 1'b1);
          end else begin
            for (i = 0; i < frame_count; i++) begin
              queue_report(ST_OK, i, param_buf[i], 1'b1, (i + 1 == frame_count));
            end
          end
        end
      end
      default: phase = HUNT;
    endcase
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare a result beat with the oldest outstanding one
  task automatic check_report();
    packet_report_t want;
    if (packet_reports.size() == 0) begin
      $error("result beat with nothing outstanding: status %0d id %0h index %0d",
             out_packet_status, out_sender_id, out_param_index);
      fail_count++;
    end else begin
      want = packet_reports.pop_front();
      result_count++;
      check_field("packet_status", want.status, out_packet_status);
      check_field("sender_id", want.sender_id, out_sender_id);
      check_field("instruction_code", want.instr, out_instruction_code);
      check_field("param_total", want.total, out_param_total);
      check_field("param_index", want.index, out_param_index);
      check_field("param_value", want.value, out_param_value);
      check_field("param_present", want.present, out_param_present);
      check_field("last_of_packet", want.last, out_last_of_packet);
    end
  endtask

  // Drain results before taking the new byte so a stray beat is never hidden
  always @(posedge clk) begin
    if (!rst_n) begin
      phase        = HUNT;
      frame_id     = '0;
      frame_count  = '0;
      frame_instr  = '0;
      frame_sum    = '0;
      body_pos     = '0;
      fail_count   = 0;
      result_count = 0;
      packet_reports.delete();
      pending_count <= 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) check_report();
      if (in_valid === 1'b1 && in_stall === 1'b0) parse_byte(in_rx_byte);
      pending_count <= packet_reports.size();
    end
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus for the servo bus packet parser: a few directed frames
// for the corner cases, then random frames, broken headers, oversize frames
// and line noise under three sender/receiver idle patterns and one long
// receiver hold-off. The packet checker does all comparison.
// ----------------------------------------------------------------------------
module testbench
  import sbpp_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PARAMS   = 64;
  localparam int RANDOM_BYTES = 12;
  localparam int CYCLE_LIMIT  = 400000;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [STAT_W-1:0] out_packet_status;
  logic [BYTE_W-1:0] out_sender_id;
  logic [BYTE_W-1:0] out_instruction_code;
  logic [BYTE_W-1:0] out_param_total;
  logic [IDX_W-1:0]  out_param_index;
  logic [BYTE_W-1:0] out_param_value;
  logic              out_param_present;
  logic              out_last_of_packet;

  int fail_count;
  int pending_count;
  int result_count;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;
  int hold_left      = 0;
  int cycle_count    = 0;

  int bytes_sent    = 0;
  int frames_sent   = 0;
  int too_long_sent = 0;
  int bad_sum_sent  = 0;

  servo_bus_packet_parser #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_packet_status   (out_packet_status),
    .out_sender_id       (out_sender_id),
    .out_instruction_code(out_instruction_code),
    .out_param_total     (out_param_total),
    .out_param_index     (out_param_index),
    .out_param_value     (out_param_value),
    .out_param_present   (out_param_present),
    .out_last_of_packet  (out_last_of_packet)
  );

  packet_checker #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_packet_status   (out_packet_status),
    .out_sender_id       (out_sender_id),
    .out_instruction_code(out_instruction_code),
    .out_param_total     (out_param_total),
    .out_param_index     (out_param_index),
    .out_param_value     (out_param_value),
    .out_param_present   (out_param_present),
    .out_last_of_packet  (out_last_of_packet),
    .fail_count          (fail_count),
    .pending_count       (pending_count),
    .result_count        (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stall, or a long hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 400;
        out_stall    <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one byte, idling at random first; return at the next falling edge
  task automatic send_beat(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send a full frame with random parameter bytes; optionally spoil the checksum
  task automatic send_packet(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] len,
                             input logic [BYTE_W-1:0] instr, input bit corrupt);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] pb;
    int                n;
    int                k;
    n   = (len >= LEN_BIAS) ? len - LEN_BIAS : len;
    sum = id + len + instr;
    send_beat(HDR_BYTE);
    send_beat(HDR_BYTE);
    send_beat(id);
    send_beat(len);
    send_beat(instr);
    for (k = 0; k < n; k++) begin
      pb  = BYTE_W'($urandom);
      sum = sum + pb;
      send_beat(pb);
    end
    if (corrupt) send_beat(~sum ^ BYTE_W'($urandom_range(1, 255)));
    else send_beat(~sum);
    frames_sent++;
    if (n > MAX_PARAMS) too_long_sent++;
    else if (corrupt) bad_sum_sent++;
  endtask

  // Mostly well-formed frames with random content, plus noise and broken headers
  task automatic random_traffic(input int byte_goal);
    int pick;
    int k;
    byte_goal = bytes_sent + byte_goal;
    while (bytes_sent < byte_goal) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // line noise that never looks like a header
        for (k = 0; k <= $urandom_range(2); k++) send_beat(BYTE_W'($urandom_range(254)));
      end else if (pick < 11) begin
        send_beat(HDR_BYTE);
        send_beat(BYTE_W'($urandom_range(254)));
      end else if (pick < 14) begin
        send_packet(BYTE_W'($urandom), BYTE_W'(MAX_PARAMS + 3 + $urandom_range(3)),
                    BYTE_W'($urandom), $urandom_range(1));
      end else if (pick < 16) begin
        send_packet(BYTE_W'($urandom), BYTE_W'(MAX_PARAMS + 2), BYTE_W'($urandom), 1'b0);
      end else begin
        send_packet(BYTE_W'($urandom), BYTE_W'($urandom_range(10)), BYTE_W'($urandom),
                    ($urandom_range(99) < 15));
      end
    end
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: header that breaks after one 0xFF
    send_beat(HDR_BYTE);
    send_beat(8'h00);
    // id of 0xFF right after a full header, no parameters
    send_packet(8'hFF, LEN_BIAS, 8'h00, 1'b0);
    // length 0 and length 1 are taken as the count itself
    send_packet(8'h00, 8'd0, 8'hFF, 1'b0);
    send_packet(8'h5A, 8'd1, 8'hA5, 1'b0);
    // checksum mismatch
    send_packet(8'h01, 8'd3, 8'h03, 1'b1);

    // Sender idles often, receiver stalls most of the time; oversize frame
    // with a bad checksum still reports too long
    send_idle_pct  = 35;
    recv_stall_pct = 76;
    send_packet(8'h21, BYTE_W'(MAX_PARAMS + 3), 8'h02, 1'b1);
    random_traffic(RANDOM_BYTES);

    // Roles swapped
    send_idle_pct  = 76;
    recv_stall_pct = 35;
    send_packet(8'h7E, BYTE_W'(MAX_PARAMS + 2), 8'h83, 1'b0);
    random_traffic(RANDOM_BYTES);

    // No idling; hold the receiver off while frames keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    for (k = 0; k < 4; k++) begin
      send_packet(BYTE_W'($urandom), BYTE_W'($urandom_range(4, 9)), BYTE_W'($urandom), 1'b0);
    end
    random_traffic(RANDOM_BYTES);

    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (2 * MAX_PARAMS + 8) @(posedge clk);

    $display("sent %0d bytes in %0d frames (%0d oversize, %0d with a bad checksum)",
             bytes_sent, frames_sent, too_long_sent, bad_sum_sent);
    $display("compared %0d result beats under three idle patterns and a long hold-off",
             result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sbpp_pkg.sv
rtl/sbpp_ram.sv
rtl/sbpp_ctrl.sv
rtl/sbpp_dp.sv
rtl/servo_bus_packet_parser.sv
bench/packet_checker.sv
bench/testbench.sv
